// ===== rtl/core/wbps_pkg.sv =====
// Package for the wildcard byte pattern search.
// Holds the word types of all channels, the pattern setup struct and register indexes.
// No dependencies.
package wbps_pkg;

  localparam int unsigned CFG_BYTES = 16;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned RES_W     = 32;

  localparam logic [IDX_W-1:0] REG_PAT_LOW  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PAT_HIGH = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_WILD     = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_LEN      = IDX_W'(3);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_region;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [RES_W-1:0] match_offset;
  } out_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
  } cfg_word_t;

  typedef struct packed {
    logic [CFG_BYTES-1:0][7:0] pat;
    logic [CFG_BYTES-1:0]      wild;
    logic [LEN_W-1:0]          len;
  } pat_cfg_t;

endpackage

// ===== rtl/core/wbps_word_if.sv =====
// Valid/ready channel interface carrying one word of a chosen type.
// Used by all channels of the pattern search; no dependencies.
interface wbps_word_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/wbps_cell.sv =====
// One cell of the window chain: compares the byte it sees against its pattern byte
// and stores that byte for the next cell. Depends on wbps_pkg.
module wbps_cell import wbps_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic       clk_i,
  input  pat_cfg_t   cfg_i,
  input  logic [7:0] byte_i,
  input  logic       shift_i,
  output logic [7:0] byte_o,
  output logic       ok_o
);

  logic [7:0]       byte_q;
  logic [LEN_W-1:0] pos;
  logic [3:0]       sel;
  logic             active;

  assign active = cfg_i.len > LEN_W'(IDX);
  assign pos    = cfg_i.len - LEN_W'(1) - LEN_W'(IDX);
  assign sel    = pos[3:0];
  assign ok_o   = !active || cfg_i.wild[sel] || (byte_i == cfg_i.pat[sel]);

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

// ===== rtl/core/wildcard_byte_pattern_search.sv =====
// Top level of the wildcard byte pattern search: setup registers, cell chain,
// byte counter and output register. Depends on wbps_pkg, wbps_word_if and wbps_cell.
//
//   channel  dir  word                              handshake
//   in_i     in   data_byte, last_of_region         valid/ready
//   out_o    out  found, match_offset               valid/ready
//   cfg_i    in   index, data (64 bits)             valid/ready, always ready
//
// One byte is taken every cycle unless stalled; a result is shown in the cycle after its byte.
// All pattern positions compare in the same cycle, one cell per position.
// The input stalls only while a result waits and out_o.ready is low.
// Reset clears the setup registers, the count, the done flag and the result valid flag.
module wildcard_byte_pattern_search import wbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  wbps_word_if.sink   in_i,
  wbps_word_if.source out_o,
  wbps_word_if.sink   cfg_i
);

  localparam int unsigned LIM = (MAX_PATTERN < CFG_BYTES) ? MAX_PATTERN : CFG_BYTES;

  logic [CFG_W-1:0]     pat_low_q, pat_high_q;
  logic [CFG_BYTES-1:0] wild_q;
  logic [LEN_W-1:0]     len_q;
  logic [LEN_W-1:0]     len_lim, len_m1;
  pat_cfg_t             cfg_eff;

  logic [OFFSET_BITS-1:0] cnt_q, cnt_d, off_full;
  logic                   done_q, done_d;
  logic [RES_W-1:0]       off32;
  logic                   out_valid_q;
  out_word_t              out_q;

  logic [7:0]     win [LIM];
  logic [LIM-1:0] ok;
  logic           accept, last, hit, emit;

  in_word_t in_word;
  cfg_word_t cfg_word;

  assign in_word  = in_i.data;
  assign cfg_word = cfg_i.data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      wild_q     <= '0;
      len_q      <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_word.index)
        REG_PAT_LOW:  pat_low_q  <= cfg_word.data;
        REG_PAT_HIGH: pat_high_q <= cfg_word.data;
        REG_WILD:     wild_q     <= cfg_word.data[CFG_BYTES-1:0];
        REG_LEN:      len_q      <= cfg_word.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_lim = (len_q > LEN_W'(LIM)) ? LEN_W'(LIM) : len_q;
  assign len_m1  = len_lim - LEN_W'(1);

  assign cfg_eff.pat  = {pat_high_q, pat_low_q};
  assign cfg_eff.wild = wild_q;
  assign cfg_eff.len  = len_lim;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign last       = in_word.last_of_region;

  assign win[0] = in_word.data_byte;

  for (genvar b = 0; b < LIM; b++) begin : g_cell
    if (b < LIM - 1) begin : g_mid
      wbps_cell #(.IDX(b)) u_cell (
        .clk_i  (clk_i),
        .cfg_i  (cfg_eff),
        .byte_i (win[b]),
        .shift_i(accept),
        .byte_o (win[b+1]),
        .ok_o   (ok[b])
      );
    end else begin : g_tail
      wbps_cell #(.IDX(b)) u_cell (
        .clk_i  (clk_i),
        .cfg_i  (cfg_eff),
        .byte_i (win[b]),
        .shift_i(accept),
        .byte_o (),
        .ok_o   (ok[b])
      );
    end
  end

  assign hit = !done_q && (len_lim != '0) && (cnt_q >= OFFSET_BITS'(len_m1)) && (&ok);
  assign emit = hit || (!done_q && last);
  assign off_full = cnt_q - OFFSET_BITS'(len_m1);

  if (OFFSET_BITS >= RES_W) begin : g_off_trunc
    assign off32 = off_full[RES_W-1:0];
  end else begin : g_off_ext
    assign off32 = {{(RES_W - OFFSET_BITS){1'b0}}, off_full};
  end

  always_comb begin
    cnt_d  = cnt_q;
    done_d = done_q;
    if (accept) begin
      if (last) begin
        cnt_d  = '0;
        done_d = 1'b0;
      end else begin
        if (cnt_q != '1) begin
          cnt_d = cnt_q + OFFSET_BITS'(1);
        end
        done_d = done_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_q.found        <= hit;
      out_q.match_offset <= hit ? off32 : '0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ===== rtl/core/wbps_checker.sv =====
// Port-level checks for the wildcard byte pattern search, bound to its top level.
// Depends on wbps_pkg.
module wbps_checker import wbps_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_word))
    else $error("result word changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_word.found |-> out_word.match_offset == '0)
    else $error("not-found word carries a nonzero offset");

  a_new_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !($past(out_valid) && !$past(out_ready)) |-> $past(in_valid && in_ready))
    else $error("result word without an accepted input word");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no waiting result");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_i.valid),
  .in_ready (in_i.ready),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .out_word (out_o.data)
);
